// File: sv/ttlb_pkg.sv
package ttlb_pkg;

  // Terminal byte codes
  localparam logic [7:0] BYTE_BS    = 8'd8;
  localparam logic [7:0] BYTE_DEL   = 8'd127;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_PLUS  = 8'd43;
  localparam logic [7:0] BYTE_MINUS = 8'd45;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;

  // Command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CELL,
    ST_LEN_RD,
    ST_LEN_CHK,
    ST_BACK_RD,
    ST_BACK_CHK,
    ST_COPY_RD,
    ST_COPY_CHK,
    ST_COPY_TERM,
    ST_COPY_CUT,
    ST_APP_CHAR,
    ST_APP_TERM,
    ST_FOLLOW,
    ST_RESP
  } state_t;

endpackage

// File: sv/text_terminal_line_buffer.sv
// Text store of a character terminal.
// Input channel: one beat is taken at a rising edge with start high and busy
// low. in_command selects a received byte (in_data_byte) or a read of one
// cell (in_read_row, in_read_col). busy stays high until the result is out.
// Result channel: out_valid is high for exactly one cycle, with the read
// cell (zero for a byte), cursor, window top and refresh flag. The receiver
// cannot hold a result off, so none is ever stalled.
// States from the accepted beat to the result: a read passes ST_DISPATCH,
// ST_CELL and ST_RESP; '+', '-' and ignored bytes pass ST_DISPATCH and
// ST_RESP; backspace and carriage return also pass ST_FOLLOW; an appended
// character passes ST_APP_CHAR, ST_APP_TERM and ST_FOLLOW as well. The
// sequencer returns to ST_IDLE after each result before the next beat can be
// taken. Backspace at column 0 of a row below the top scans the row above a
// character at a time; a word wrap scans back to the last space and copies
// the word, a cell at a time. Both are paced by the sequencer over the text
// memory's write port and registered read port.
// Reset: cursor and window top go to zero and a clearing pass writes zero to
// all ROW_COUNT*(COL_COUNT+1) cells (380 by default), one a cycle; busy is
// high during that pass.
module text_terminal_line_buffer
  import ttlb_pkg::*;
#(
  parameter int ROW_COUNT   = 20,
  parameter int COL_COUNT   = 18,
  parameter int WINDOW_ROWS = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_command,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_read_row,
  input  logic [4:0] in_read_col,
  output logic       out_valid,
  output logic [6:0] out_cell_char,
  output logic [4:0] out_cursor_row_out,
  output logic [4:0] out_cursor_col_out,
  output logic [3:0] out_window_top,
  output logic       out_refresh
);

  localparam int ROW_CELLS = COL_COUNT + 1;
  localparam int CELLS     = ROW_COUNT * ROW_CELLS;
  localparam int AW        = $clog2(CELLS);
  localparam int RW        = $clog2(ROW_COUNT);
  localparam int CW        = $clog2(ROW_CELLS);
  localparam bit SCROLL_CAP = (WINDOW_ROWS <= ROW_COUNT);

  state_t        state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] scroll_r, scroll_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          cmd_r;
  logic [7:0]    byte_r;
  logic [4:0]    rd_row_r;
  logic [4:0]    rd_col_r;
  logic          rd_ok_r;
  logic [6:0]    cell_r, cell_nxt;
  logic          refresh_r, refresh_nxt;

  logic [6:0]    mem [CELLS];
  logic [6:0]    rdata_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [6:0]    wdata;
  logic [AW-1:0] raddr;

  logic          accept;
  logic          is_bs, is_cr, is_plus, is_minus, is_print, is_space;
  logic          col_full, row_last;
  logic [CW:0]   copy_pos;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    cell_addr = AW'(r) * AW'(ROW_CELLS) + AW'(c);
  endfunction

  assign accept   = start && !busy;
  assign is_bs    = (byte_r == BYTE_BS) || (byte_r == BYTE_DEL);
  assign is_cr    = (byte_r == BYTE_CR);
  assign is_plus  = (byte_r == BYTE_PLUS);
  assign is_minus = (byte_r == BYTE_MINUS);
  assign is_space = (byte_r == BYTE_SPACE);
  assign is_print = (byte_r >= PRINT_LO) && (byte_r <= PRINT_HI);
  assign col_full = (col_r >= CW'(COL_COUNT));
  assign row_last = (row_r >= RW'(ROW_COUNT - 1));
  assign copy_pos = {1'b0, idx_r} + {1'b0, k_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (cmd_r == CMD_READ) begin
          state_nxt = ST_CELL;
        end else if (is_bs) begin
          state_nxt = (col_r == '0 && row_r != '0) ? ST_LEN_RD : ST_FOLLOW;
        end else if (is_cr) begin
          state_nxt = ST_FOLLOW;
        end else if (is_plus || is_minus) begin
          state_nxt = ST_RESP;
        end else if (is_print) begin
          if (!col_full)               state_nxt = ST_APP_CHAR;
          else if (is_space || row_last) state_nxt = ST_FOLLOW;
          else                         state_nxt = ST_BACK_RD;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_CELL: state_nxt = ST_RESP;
      ST_LEN_RD: begin
        state_nxt = (idx_r == CW'(COL_COUNT)) ? ST_FOLLOW : ST_LEN_CHK;
      end
      ST_LEN_CHK: begin
        state_nxt = (rdata_r == '0) ? ST_FOLLOW : ST_LEN_RD;
      end
      ST_BACK_RD: begin
        state_nxt = (idx_r == '0) ? ST_FOLLOW : ST_BACK_CHK;
      end
      ST_BACK_CHK: begin
        state_nxt = (rdata_r == BYTE_SPACE[6:0]) ? ST_COPY_RD : ST_BACK_RD;
      end
      ST_COPY_RD: begin
        state_nxt = (copy_pos == (CW+1)'(ROW_CELLS)) ? ST_COPY_TERM : ST_COPY_CHK;
      end
      ST_COPY_CHK: begin
        state_nxt = (rdata_r == '0) ? ST_COPY_TERM : ST_COPY_RD;
      end
      ST_COPY_TERM: state_nxt = ST_COPY_CUT;
      ST_COPY_CUT: begin
        state_nxt = (k_r < CW'(COL_COUNT)) ? ST_APP_CHAR : ST_FOLLOW;
      end
      ST_APP_CHAR:  state_nxt = ST_APP_TERM;
      ST_APP_TERM:  state_nxt = ST_FOLLOW;
      ST_FOLLOW:    state_nxt = ST_RESP;
      ST_RESP:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    scroll_nxt  = scroll_r;
    idx_nxt     = idx_r;
    k_nxt       = k_r;
    clr_nxt     = clr_r;
    cell_nxt    = cell_r;
    refresh_nxt = refresh_r;
    we          = 1'b0;
    waddr       = cell_addr(row_r, col_r);
    wdata       = '0;
    raddr       = cell_addr(row_r, idx_r);
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = AW'(clr_r + 1'b1);
      end
      ST_IDLE: ;
      ST_DISPATCH: begin
        if (cmd_r == CMD_READ) begin
          refresh_nxt = 1'b0;
          raddr = cell_addr(RW'(rd_row_r), CW'(rd_col_r));
        end else begin
          cell_nxt    = '0;
          refresh_nxt = is_bs || is_cr || is_plus || is_minus || is_print;
          if (is_bs) begin
            if (col_r != '0) begin
              col_nxt = CW'(col_r - 1'b1);
              we      = 1'b1;
              waddr   = cell_addr(row_r, CW'(col_r - 1'b1));
            end else if (row_r != '0) begin
              row_nxt = RW'(row_r - 1'b1);
              idx_nxt = '0;
            end
          end else if (is_cr) begin
            if (!row_last) begin
              row_nxt = RW'(row_r + 1'b1);
              col_nxt = '0;
            end
          end else if (is_plus) begin
            if (scroll_r != '0) scroll_nxt = RW'(scroll_r - 1'b1);
          end else if (is_minus) begin
            if ((!SCROLL_CAP || int'(scroll_r) < ROW_COUNT - WINDOW_ROWS)
                && scroll_r < row_r)
              scroll_nxt = RW'(scroll_r + 1'b1);
          end else if (is_print && col_full) begin
            if (is_space) begin
              if (!row_last) begin
                row_nxt = RW'(row_r + 1'b1);
                col_nxt = '0;
              end
            end else begin
              idx_nxt = col_r;
            end
          end
        end
      end
      ST_CELL: begin
        cell_nxt = rd_ok_r ? rdata_r : '0;
      end
      ST_LEN_RD: begin
        // row is full length: drop its last character
        if (idx_r == CW'(COL_COUNT)) begin
          col_nxt = CW'(COL_COUNT - 1);
          we      = 1'b1;
          waddr   = cell_addr(row_r, CW'(COL_COUNT - 1));
        end
      end
      ST_LEN_CHK: begin
        if (rdata_r == '0) begin
          if (idx_r != '0) begin
            col_nxt = CW'(idx_r - 1'b1);
            we      = 1'b1;
            waddr   = cell_addr(row_r, CW'(idx_r - 1'b1));
          end else begin
            col_nxt = '0;
          end
        end else begin
          idx_nxt = CW'(idx_r + 1'b1);
        end
      end
      ST_BACK_RD: begin
        raddr = cell_addr(row_r, CW'(idx_r - 1'b1));
      end
      ST_BACK_CHK: begin
        if (rdata_r == BYTE_SPACE[6:0]) k_nxt = '0;
        else                            idx_nxt = CW'(idx_r - 1'b1);
      end
      ST_COPY_RD: begin
        raddr = cell_addr(row_r, CW'(copy_pos));
      end
      ST_COPY_CHK: begin
        // move one character of the trailing word down a row
        if (rdata_r != '0) begin
          we    = 1'b1;
          waddr = cell_addr(RW'(row_r + 1'b1), k_r);
          wdata = rdata_r;
          k_nxt = CW'(k_r + 1'b1);
        end
      end
      ST_COPY_TERM: begin
        we    = 1'b1;
        waddr = cell_addr(RW'(row_r + 1'b1), k_r);
      end
      ST_COPY_CUT: begin
        we      = 1'b1;
        waddr   = cell_addr(row_r, idx_r);
        row_nxt = RW'(row_r + 1'b1);
        col_nxt = k_r;
      end
      ST_APP_CHAR: begin
        we      = 1'b1;
        wdata   = byte_r[6:0];
        col_nxt = CW'(col_r + 1'b1);
      end
      ST_APP_TERM: begin
        we = 1'b1;
      end
      ST_FOLLOW: begin
        if (int'(row_r) >= int'(scroll_r) + WINDOW_ROWS)
          scroll_nxt = RW'(int'(row_r) - WINDOW_ROWS + 1);
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  // Text memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_command;
      byte_r   <= in_data_byte;
      rd_row_r <= in_read_row;
      rd_col_r <= in_read_col;
      rd_ok_r  <= (int'(in_read_row) < ROW_COUNT) && (int'(in_read_col) <= COL_COUNT);
    end
    idx_r     <= idx_nxt;
    k_r       <= k_nxt;
    cell_r    <= cell_nxt;
    refresh_r <= refresh_nxt;
  end

  // Control state and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      row_r    <= '0;
      col_r    <= '0;
      scroll_r <= '0;
      clr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      scroll_r <= scroll_nxt;
      clr_r    <= clr_nxt;
    end
  end

  // Result beat
  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = (state_r == ST_RESP);
  assign out_cell_char      = cell_r;
  assign out_cursor_row_out = 5'(row_r);
  assign out_cursor_col_out = 5'(col_r);
  assign out_window_top     = 4'(scroll_r);
  assign out_refresh        = refresh_r;

endmodule
